@@ design/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the sorted insert stack.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CountFieldW  = 7;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // broadcast from the control to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

@@ design/sis_if.sv @@
// ----------------------------------------------------------------------------
// sis_in_if / sis_out_if
// Valid/ready channels carrying the operation word and the result word.
// ----------------------------------------------------------------------------
interface sis_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sis_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] removed_value;
  logic [31:0] top_value;
  logic [6:0]  entry_count;
  logic        is_empty;

  modport source (output valid, output status, output removed_value, output top_value,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input removed_value, input top_value,
                  input entry_count, input is_empty, output ready);
endinterface

@@ design/sis_cell.sv @@
// ----------------------------------------------------------------------------
// sis_cell
// One slot of the sorted chain: compares its value with the broadcast word
// and shifts towards or away from the top.
// ----------------------------------------------------------------------------
module sis_cell import sis_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             occupied_i,
  input  logic             prev_less_i,
  input  logic [DataW-1:0] prev_data_i,
  input  logic [DataW-1:0] next_data_i,
  output logic             less_o,
  output logic [DataW-1:0] data_o,
  output logic [DataW-1:0] data_d_o
);

  logic [DataW-1:0] data_q, data_d;

  assign less_o = occupied_i & ($signed(data_q) < $signed(ctrl_i.value));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (!less_o) begin
        data_d = prev_less_i ? ctrl_i.value : prev_data_i;
      end
    end else if (ctrl_i.rem) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o   = data_q;
  assign data_d_o = data_d;

endmodule

@@ design/sorted_insert_stack.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_stack
// Bounded stack of signed 32-bit words kept sorted, smallest on top.
// ----------------------------------------------------------------------------
// in_i carries one operation word: insert value, or remove the top.
// out_o returns one result word per operation: status, removed value,
// new top value, entry count and empty flag.
// The stack is a row of DEPTH cells, cell 0 on top. Each cell compares
// its own value against the broadcast input word; on insert the cells
// at and below the insertion point shift down by one, on remove every
// cell takes its lower neighbour's value, all in the same clock.
// The result is valid in the cycle after acceptance, and
// one operation is taken every cycle while out_o is being drained.
// The result sits in an output register; when the receiver stalls,
// in_i.ready drops until that word is taken, and nothing is lost.
// Reset clears the entry count and the output valid; cell contents are
// not cleared and are never read beyond the count.
// ----------------------------------------------------------------------------
module sorted_insert_stack import sis_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sis_in_if.sink    in_i,
  sis_out_if.source out_o
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count_q, count_d;
  logic              full, empty, fire;
  cell_ctrl_t        ctrl;
  status_e           status_d;

  logic [DataW-1:0] cell_data   [DEPTH];
  logic [DataW-1:0] cell_data_d [DEPTH];
  logic             cell_less   [DEPTH];

  logic                      out_valid_q;
  logic [1:0]                status_q;
  logic [DataW-1:0]          removed_q, removed_d, top_q, top_d;
  logic [CountFieldW-1:0]    entry_q;
  logic                      empty_q;
  logic [CountW+CountFieldW-1:0] count_ext;

  assign full  = (count_q == CountW'(DEPTH));
  assign empty = (count_q == '0);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire  = in_i.valid && in_i.ready;

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.value = in_i.value;
    status_d   = StOk;
    count_d    = count_q;
    removed_d  = '0;
    if (fire) begin
      unique case (op_e'(in_i.operation))
        OpInsert: begin
          if (full) begin
            status_d = StFull;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CountW'(1);
          end
        end
        OpRemove: begin
          if (empty) begin
            status_d = StEmpty;
          end else begin
            ctrl.rem  = 1'b1;
            count_d   = count_q - CountW'(1);
            removed_d = cell_data[0];
          end
        end
        default: status_d = StOk;
      endcase
    end
    top_d = (count_d != '0) ? cell_data_d[0] : '0;
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic             prev_less;
    logic [DataW-1:0] prev_data, next_data;
    logic             occupied;

    assign occupied = (CountW'(j) < count_q);

    if (j == 0) begin : g_top
      assign prev_less = 1'b1;
      assign prev_data = ctrl.value;
    end else begin : g_mid
      assign prev_less = cell_less[j-1];
      assign prev_data = cell_data[j-1];
    end

    if (j == DEPTH - 1) begin : g_bottom
      assign next_data = '0;
    end else begin : g_above
      assign next_data = cell_data[j+1];
    end

    sis_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied),
      .prev_less_i (prev_less),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .less_o      (cell_less[j]),
      .data_o      (cell_data[j]),
      .data_d_o    (cell_data_d[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = {{CountFieldW{1'b0}}, count_d};

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      top_q     <= top_d;
      entry_q   <= count_ext[CountFieldW-1:0];
      empty_q   <= (count_d == '0);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.removed_value = removed_q;
  assign out_o.top_value     = top_q;
  assign out_o.entry_count   = entry_q;
  assign out_o.is_empty      = empty_q;

endmodule

@@ tb/sv/stack_result_checker.sv @@
// ----------------------------------------------------------------------------
// stack_result_checker
// Watches both channels of the sorted insert stack, keeps its own sorted
// copy of the stored values, predicts the result word of every accepted
// operation word and compares each returned word field by field in order.
// ----------------------------------------------------------------------------
module stack_result_checker import sis_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sis_in_if    in_w,
  sis_out_if   out_w,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   full_seen,
  output int   empty_seen,
  output int   peak_depth
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e                status;
    logic [DataW-1:0]       removed_value;
    logic [DataW-1:0]       top_value;
    logic [CountFieldW-1:0] entry_count;
    logic                   is_empty;
  } stack_result_t;

  // index 0 is the bottom (largest), the last entry is the top (smallest)
  logic signed [DataW-1:0] sorted_copy[$];
  stack_result_t           due_results[$];

  int err_total;
  int words_back;
  int full_n;
  int empty_n;
  int peak_n;

  task automatic report_mismatch(string msg);
    err_total++;
    if (err_total <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic stack_result_t apply_word(logic op, logic signed [DataW-1:0] val);
    stack_result_t r;
    int            pos;
    r        = '0;
    r.status = StOk;
    if (op == OpInsert) begin
      if (sorted_copy.size() >= DEPTH) begin
        r.status = StFull;
      end else begin
        pos = sorted_copy.size();
        while (pos > 0 && sorted_copy[pos-1] < val) pos--;
        sorted_copy.insert(pos, val);
      end
    end else if (sorted_copy.size() == 0) begin
      r.status = StEmpty;
    end else begin
      r.removed_value = sorted_copy.pop_back();
    end
    if (sorted_copy.size() > 0) r.top_value = sorted_copy[sorted_copy.size()-1];
    r.entry_count = CountFieldW'(sorted_copy.size());
    r.is_empty    = (sorted_copy.size() == 0);
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    stack_result_t want;
    stack_result_t made;
    if (rst_ni) begin
      // compare first: a word taken at this edge belongs to an earlier operation
      if (out_w.valid && out_w.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing due", words_back));
        end else begin
          want = due_results.pop_front();
          if (out_w.status !== want.status)
            report_mismatch($sformatf("word %0d status got %0d want %0d",
                                      words_back, out_w.status, want.status));
          if (out_w.removed_value !== want.removed_value)
            report_mismatch($sformatf("word %0d removed_value got %0h want %0h",
                                      words_back, out_w.removed_value, want.removed_value));
          if (out_w.top_value !== want.top_value)
            report_mismatch($sformatf("word %0d top_value got %0h want %0h",
                                      words_back, out_w.top_value, want.top_value));
          if (out_w.entry_count !== want.entry_count)
            report_mismatch($sformatf("word %0d entry_count got %0d want %0d",
                                      words_back, out_w.entry_count, want.entry_count));
          if (out_w.is_empty !== want.is_empty)
            report_mismatch($sformatf("word %0d is_empty got %0b want %0b",
                                      words_back, out_w.is_empty, want.is_empty));
        end
        words_back++;
      end
      if (in_w.valid && in_w.ready) begin
        made = apply_word(in_w.operation, in_w.value);
        if (made.status == StFull)  full_n++;
        if (made.status == StEmpty) empty_n++;
        if (sorted_copy.size() > peak_n) peak_n = sorted_copy.size();
        due_results.push_back(made);
      end
    end
    fail_count   <= err_total;
    pending      <= due_results.size();
    results_seen <= words_back;
    full_seen    <= full_n;
    empty_seen   <= empty_n;
    peak_depth   <= peak_n;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted insert stack: a short directed run
// over extreme and equal values and pops of an empty stack, then random
// phases that fill, drain and mix, with random gaps on both channels, two
// long receiver hold-offs and pauses until every result word is back.
// ----------------------------------------------------------------------------
module tb_top;
  import sis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = 64;
  localparam int          StallLimit = 1000;
  localparam int          WordTarget = 550;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rush  = 1'b0;

  int words_sent    = 0;
  int results_taken = 0;
  int fail_count;
  int pending;
  int results_seen;
  int full_seen;
  int empty_seen;
  int peak_depth;

  sis_in_if  in_w();
  sis_out_if out_w();

  sorted_insert_stack #(.DEPTH(StackDepth)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  stack_result_checker #(.DEPTH(StackDepth)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_w),
    .out_w        (out_w),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .empty_seen   (empty_seen),
    .peak_depth   (peak_depth)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return DataW'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(op_e op, logic [DataW-1:0] val);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.operation <= op;
    in_w.value     <= val;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // hold the input channel until every result word is back
  task automatic settle();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          phase;
    int          span;
    int          ins_pct;
    op_e         op;
    logic [31:0] dir_vals[10];
    dir_vals = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h5555_5555, 32'haaaa_aaaa};
    in_w.valid     <= 1'b0;
    in_w.operation <= OpInsert;
    in_w.value     <= '0;
    rst_ni         <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pop of an empty stack, extremes and equal values, then drain past empty
    send_word(OpRemove, 32'hffff_ffff);
    foreach (dir_vals[i]) send_word(OpInsert, dir_vals[i]);
    repeat (11) send_word(OpRemove, $urandom);
    settle();

    phase = 0;
    while (words_sent < WordTarget) begin
      if (phase == 0) begin
        ins_pct = 100;
        span    = 70;
      end else begin
        case ($urandom_range(0, 3))
          0:       ins_pct = 90;
          1:       ins_pct = 10;
          default: ins_pct = 50;
        endcase
        span = $urandom_range(30, 80);
      end
      if (phase == 4) settle();
      rush = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        if (words_sent >= WordTarget) break;
        op = ($urandom_range(0, 99) < ins_pct) ? OpInsert : OpRemove;
        send_word(op, rand_value());
      end
      phase++;
    end
    rush = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d words in %0d phases, peak depth %0d of %0d", results_seen,
             phase, peak_depth, StackDepth);
    $display("%0d inserts refused on a full stack, %0d pops of an empty stack",
             full_seen, empty_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : drain_results
    int stall;
    out_w.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (results_taken == 120 || results_taken == 380) begin
        stall = 60;
      end else begin
        stall = rush ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_w.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_w.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_w.valid) @(posedge clk_i);
      results_taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no handshake on either channel for %0d cycles", quiet);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
